FILE: hdl/gmdp_pkg.sv
// ----------------------------------------------------------------------------
// gmdp_pkg
// Shared types and constants of the maximum descending path block: the
// fixed widths of the configuration and result words, and the queue depth.
// ----------------------------------------------------------------------------
package gmdp_pkg;

    // Width and reset value of the grid size register.
    localparam int SIZE_BITS  = 7;
    localparam int SIZE_RESET = 4;

    // Result word fields.
    localparam int SUM_OUT_BITS   = 22;
    localparam int COL_OUT_BITS   = 7;
    localparam int OUT_TDATA_BITS = 32;
    localparam int OUT_PAD_BITS   = OUT_TDATA_BITS - SUM_OUT_BITS - COL_OUT_BITS;

    // Depth of the result queue and the width of its fill count.
    localparam int RES_DEPTH     = 4;
    localparam int RES_PTR_BITS  = 2;
    localparam int RES_CNT_BITS  = 3;

    // One result word, best_sum in the low bits.
    typedef struct packed {
        logic [COL_OUT_BITS-1:0]        best_column;
        logic signed [SUM_OUT_BITS-1:0] best_sum;
    } result_t;

endpackage

FILE: hdl/gmdp_row_mem.sv
// ----------------------------------------------------------------------------
// gmdp_row_mem
// Row buffer of running path sums: one write port and one read port with
// a registered read that only updates when a read is requested.
// ----------------------------------------------------------------------------
module gmdp_row_mem #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 23
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    // Write port.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read port; the data holds until the next read.
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: hdl/gmdp_out_fifo.sv
// ----------------------------------------------------------------------------
// gmdp_out_fifo
// Small result queue between the path sum pipeline and the output stream.
// It lets the input side keep running while results wait to be taken.
// ----------------------------------------------------------------------------
module gmdp_out_fifo (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               push,
    input  gmdp_pkg::result_t                  push_word,
    input  logic                               pop,
    output logic                               not_empty,
    output gmdp_pkg::result_t                  head_word,
    output logic [gmdp_pkg::RES_CNT_BITS-1:0]  count
);

    import gmdp_pkg::*;

    result_t                 slot_reg [RES_DEPTH];
    logic [RES_PTR_BITS-1:0] wr_ptr_reg;
    logic [RES_PTR_BITS-1:0] rd_ptr_reg;
    logic [RES_CNT_BITS-1:0] count_reg;
    logic                    do_pop;

    assign do_pop = pop && (count_reg != '0);

    // Storage; no reset needed on the payload.
    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wr_ptr_reg] <= push_word;
        end
    end

    // Pointers and fill count.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + RES_PTR_BITS'(1);
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + RES_PTR_BITS'(1);
            end
            if (push && !do_pop) begin
                count_reg <= count_reg + RES_CNT_BITS'(1);
            end else if (!push && do_pop) begin
                count_reg <= count_reg - RES_CNT_BITS'(1);
            end
        end
    end

    assign not_empty = (count_reg != '0);
    assign head_word = slot_reg[rd_ptr_reg];
    assign count     = count_reg;

endmodule

FILE: hdl/grid_max_descending_path.sv
// ----------------------------------------------------------------------------
// grid_max_descending_path
// Maximum falling path sum over a square grid streamed in row-major order.
// ----------------------------------------------------------------------------
// The block takes one grid cell per clock cycle. Each accepted cell issues a
// read of the row buffer one column ahead (the first column when the cell
// ends a row); the cycle after, the cell's sum is formed from a three-way
// maximum and one add and written back at its own column. Previous-row sums
// of the left and own columns are kept in a small window of registers, and a
// write that hits the address being read in the same cycle is forwarded. After
// the last cell of the grid, stage B pushes the best bottom-row sum and its
// 1-based column as a result word. Results pass through a four-word queue,
// so the input only stalls when four results are waiting, or three are
// waiting while a fourth is being queued. A write to grid_size starts a new
// grid; values of 0 act as 1, and values above MAX_SIZE act as MAX_SIZE.
// ----------------------------------------------------------------------------
module grid_max_descending_path #(
    parameter int MAX_SIZE   = 64,
    parameter int VALUE_BITS = 16
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    // Configuration: grid_size.
    input  logic                                  cfg_wr_en,
    input  logic [gmdp_pkg::SIZE_BITS-1:0]        cfg_wr_data,
    // Input stream; tdata: cell_value, zero-filled to whole bytes.
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_tdata,
    // Result stream; tdata: best_sum [21:0], best_column [28:22], zeros.
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    output logic [gmdp_pkg::OUT_TDATA_BITS-1:0]   m_tdata
);

    import gmdp_pkg::*;

    localparam int COL_BITS = $clog2(MAX_SIZE);
    localparam int SUM_BITS = VALUE_BITS + COL_BITS + 1;

    // Configuration and grid position.
    logic [SIZE_BITS-1:0] grid_size_reg;
    logic [COL_BITS-1:0]  last_col;
    logic [COL_BITS-1:0]  c_reg, c_next;
    logic [COL_BITS-1:0]  r_reg, r_next;
    logic                 accept;
    logic                 c_last;
    logic                 r_last;
    logic [COL_BITS-1:0]  rd_addr;

    // Stage B: the cell whose row buffer read is in flight.
    logic                         b_valid_reg;
    logic signed [VALUE_BITS-1:0] b_value_reg;
    logic [COL_BITS-1:0]          b_col_reg;
    logic                         b_first_reg;
    logic                         b_lastc_reg;
    logic                         b_lastr_reg;
    logic                         b_row0_reg;

    // Previous-row window and forwarding.
    logic signed [SUM_BITS-1:0] left_reg, left_next;
    logic signed [SUM_BITS-1:0] here_reg, here_next;
    logic                       fwd_reg;
    logic signed [SUM_BITS-1:0] fwd_data_reg;
    logic [SUM_BITS-1:0]        mem_rd_data;
    logic signed [SUM_BITS-1:0] right_sum;
    logic signed [SUM_BITS-1:0] max_a;
    logic signed [SUM_BITS-1:0] max_b;
    logic signed [SUM_BITS-1:0] cell_sum;

    // Best bottom-row sum.
    logic signed [SUM_BITS-1:0] best_reg, best_next;
    logic [COL_BITS-1:0]        best_col_reg, best_col_next;
    logic                       b_emit;
    result_t                    res_word;
    result_t                    head_word;
    logic                       res_not_empty;
    logic [RES_CNT_BITS-1:0]    res_count;

    // Effective last column index from the size register.
    always_comb begin
        if (grid_size_reg == '0) begin
            last_col = '0;
        end else if (32'(grid_size_reg) > 32'(MAX_SIZE)) begin
            last_col = COL_BITS'(MAX_SIZE - 1);
        end else begin
            last_col = COL_BITS'(grid_size_reg - SIZE_BITS'(1));
        end
    end

    assign b_emit   = b_valid_reg && b_lastr_reg && b_lastc_reg;
    assign s_tready = (res_count + RES_CNT_BITS'(b_emit)) < RES_CNT_BITS'(RES_DEPTH);
    assign accept   = s_tvalid && s_tready;
    assign c_last   = (c_reg == last_col);
    assign r_last   = (r_reg == last_col);
    assign rd_addr  = c_last ? '0 : c_reg + COL_BITS'(1);

    // Grid position after an accepted cell.
    always_comb begin
        c_next = c_reg;
        r_next = r_reg;
        if (accept) begin
            if (c_last) begin
                c_next = '0;
                r_next = r_last ? '0 : r_reg + COL_BITS'(1);
            end else begin
                c_next = c_reg + COL_BITS'(1);
            end
        end
    end

    // Configuration register and position counters.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            grid_size_reg <= SIZE_BITS'(SIZE_RESET);
            c_reg         <= '0;
            r_reg         <= '0;
        end else if (cfg_wr_en) begin
            grid_size_reg <= cfg_wr_data;
            c_reg         <= '0;
            r_reg         <= '0;
        end else begin
            c_reg <= c_next;
            r_reg <= r_next;
        end
    end

    // Stage B control.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            b_valid_reg <= 1'b0;
        end else begin
            b_valid_reg <= accept;
        end
    end

    // Stage B payload and forwarding of a same-cycle write to the read address.
    always_ff @(posedge aclk) begin
        if (accept) begin
            b_value_reg  <= s_tdata[VALUE_BITS-1:0];
            b_col_reg    <= c_reg;
            b_first_reg  <= (c_reg == '0);
            b_lastc_reg  <= c_last;
            b_lastr_reg  <= r_last;
            b_row0_reg   <= (r_reg == '0);
            fwd_reg      <= b_valid_reg && (b_col_reg == rd_addr);
            fwd_data_reg <= cell_sum;
        end
    end

    gmdp_row_mem #(
        .DEPTH (MAX_SIZE),
        .WIDTH (SUM_BITS)
    ) u_row_mem (
        .aclk    (aclk),
        .wr_en   (b_valid_reg),
        .wr_addr (b_col_reg),
        .wr_data (cell_sum),
        .rd_en   (accept),
        .rd_addr (rd_addr),
        .rd_data (mem_rd_data)
    );

    // Three-way maximum over the previous row and the cell's sum.
    always_comb begin
        right_sum = fwd_reg ? fwd_data_reg : $signed(mem_rd_data);
        max_a     = (!b_first_reg && (left_reg > here_reg)) ? left_reg : here_reg;
        max_b     = (!b_lastc_reg && (right_sum > max_a)) ? right_sum : max_a;
        if (b_row0_reg) begin
            cell_sum = SUM_BITS'(b_value_reg);
        end else begin
            cell_sum = SUM_BITS'(b_value_reg) + max_b;
        end
    end

    // Window shift and best bottom-row tracking.
    always_comb begin
        left_next     = left_reg;
        here_next     = here_reg;
        best_next     = best_reg;
        best_col_next = best_col_reg;
        if (b_valid_reg) begin
            left_next = here_reg;
            here_next = right_sum;
            if (b_lastr_reg && (b_first_reg || (cell_sum > best_reg))) begin
                best_next     = cell_sum;
                best_col_next = b_col_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            left_reg     <= '0;
            here_reg     <= '0;
            best_reg     <= '0;
            best_col_reg <= '0;
        end else begin
            left_reg     <= left_next;
            here_reg     <= here_next;
            best_reg     <= best_next;
            best_col_reg <= best_col_next;
        end
    end

    // Result word for the queue.
    always_comb begin
        res_word.best_sum    = SUM_OUT_BITS'(best_next);
        res_word.best_column = COL_OUT_BITS'(32'(best_col_next) + 32'd1);
    end

    gmdp_out_fifo u_out_fifo (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push      (b_emit),
        .push_word (res_word),
        .pop       (m_tready),
        .not_empty (res_not_empty),
        .head_word (head_word),
        .count     (res_count)
    );

    assign m_tvalid = res_not_empty;
    assign m_tdata  = {OUT_PAD_BITS'(0), head_word};

    // The grid position never passes the last row or column.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (c_reg <= last_col) && (r_reg <= last_col))
    else $error("grid position beyond the grid size");

    // The input only stalls while results are waiting.
    assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid)
    else $error("input stalled with no result pending");

    // A delivered column is 1-based and at most MAX_SIZE.
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (head_word.best_column != '0) &&
                     (32'(head_word.best_column) <= 32'(MAX_SIZE)))
    else $error("result column out of range");

endmodule

FILE: dv/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the maximum descending path block. Grids of random
// size and content are streamed in one word per cell. A behavioral predictor
// tracks the running row of path sums and queues the expected best sum and
// column for every completed grid. Both stream sides idle and stall at random.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import gmdp_pkg::*;

    localparam int GRID_MAX     = 64;
    localparam int CELL_BITS    = 16;
    localparam int DRAIN_CYCLES = 8;
    localparam int RANDOM_CELLS = 1850;

    // Value styles for a grid's cells.
    typedef enum int {
        CELLS_UNIFORM,
        CELLS_TIES,
        CELLS_EXTREMES
    } cell_style_t;

    logic                      aclk = 1'b0;
    logic                      aresetn = 1'b0;
    logic                      cfg_wr_en = 1'b0;
    logic [SIZE_BITS-1:0]      cfg_wr_data = '0;
    logic                      s_tvalid = 1'b0;
    logic                      s_tready;
    logic [CELL_BITS-1:0]      s_tdata = '0;
    logic                      m_tvalid;
    logic                      m_tready = 1'b0;
    logic [OUT_TDATA_BITS-1:0] m_tdata;

    // Cells waiting for the driver and results waiting for the monitor.
    logic [CELL_BITS-1:0] pending_cells[$];
    result_t              expected_results[$];

    // Predictor state.
    logic [SIZE_BITS-1:0] grid_size_q;
    logic signed [22:0]   path_sums[GRID_MAX];
    logic signed [22:0]   left_sum;
    logic signed [22:0]   best_sum_q;
    int                   best_col_q;
    int                   col_pos;
    int                   row_pos;

    int  send_gap = 0;
    int  recv_gap = 0;
    bit  no_idling = 1'b0;
    int  error_count = 0;
    int  cells_accepted = 0;
    int  results_checked = 0;
    int  size_writes = 0;

    grid_max_descending_path #(
        .MAX_SIZE   (GRID_MAX),
        .VALUE_BITS (CELL_BITS)
    ) dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata)
    );

    always #5 aclk = ~aclk;

    task automatic report_mismatch(input string msg);
        if (error_count < 40) begin
            $display("%0t ns MISMATCH: %s", $time, msg);
        end
        error_count++;
    endtask

    function automatic int size_in_use(input logic [SIZE_BITS-1:0] size);
        if (size == 0) begin
            return 1;
        end
        if (size > GRID_MAX) begin
            return GRID_MAX;
        end
        return int'(size);
    endfunction

    // Mostly short gaps, a few long ones; none at all in burst phases.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (no_idling || r < 60) begin
            return 0;
        end
        if (r < 90) begin
            return $urandom_range(1, 3);
        end
        if (r < 98) begin
            return $urandom_range(4, 10);
        end
        return $urandom_range(20, 60);
    endfunction

    function automatic logic [CELL_BITS-1:0] pick_cell(input cell_style_t style);
        case (style)
            CELLS_TIES: begin
                return CELL_BITS'($urandom_range(0, 4)) - CELL_BITS'(2);
            end
            CELLS_EXTREMES: begin
                case ($urandom_range(0, 3))
                    0: return 16'h8000;
                    1: return 16'h7fff;
                    2: return 16'h0000;
                    default: return 16'hffff;
                endcase
            end
            default: begin
                return CELL_BITS'($urandom_range(0, 65535));
            end
        endcase
    endfunction

    // Advance the predicted row of path sums by one cell; a finished grid
    // queues its best bottom-row sum and 1-based column.
    function automatic void predict_cell(input logic signed [CELL_BITS-1:0] cell_val);
        int                 n;
        int                 col;
        int                 row;
        logic signed [22:0] here;
        logic signed [22:0] pick;
        logic signed [22:0] sum;
        result_t            want;
        n = size_in_use(grid_size_q);
        col = (col_pos >= n) ? 0 : col_pos;
        row = (row_pos >= n) ? 0 : row_pos;
        here = path_sums[col];
        if (row == 0) begin
            sum = 23'(cell_val);
        end else begin
            pick = here;
            if (col > 0 && left_sum > pick) begin
                pick = left_sum;
            end
            if (col + 1 < n && path_sums[col + 1] > pick) begin
                pick = path_sums[col + 1];
            end
            sum = 23'(cell_val) + pick;
        end
        left_sum = here;
        path_sums[col] = sum;

        // Leftmost column wins ties on the bottom row.
        if (row == n - 1 && (col == 0 || sum > best_sum_q)) begin
            best_sum_q = sum;
            best_col_q = col;
        end

        if (col + 1 >= n) begin
            col_pos = 0;
            if (row == n - 1) begin
                want.best_sum = best_sum_q[SUM_OUT_BITS-1:0];
                want.best_column = COL_OUT_BITS'(best_col_q + 1);
                expected_results.push_back(want);
                row_pos = 0;
            end else begin
                row_pos = row + 1;
            end
        end else begin
            col_pos = col + 1;
            row_pos = row;
        end
    endfunction

    // Input driver: a word leaves at each handshake, then a random gap.
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            send_gap <= 0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                predict_cell($signed(s_tdata));
                cells_accepted++;
            end
            if (send_gap > 0) begin
                s_tvalid <= 1'b0;
                send_gap <= send_gap - 1;
            end else if (pending_cells.size() > 0) begin
                s_tvalid <= 1'b1;
                s_tdata <= pending_cells.pop_front();
                send_gap <= pick_gap();
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result monitor: checks each word against the oldest expectation and
    // stalls the result stream at random.
    always @(posedge aclk) begin : result_monitor
        result_t got;
        result_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
            recv_gap <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got = m_tdata[SUM_OUT_BITS+COL_OUT_BITS-1:0];
                if (expected_results.size() == 0) begin
                    report_mismatch($sformatf("result with none expected, tdata %h", m_tdata));
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (got.best_sum !== want.best_sum) begin
                        report_mismatch($sformatf("best_sum %0d, expected %0d",
                                                  got.best_sum, want.best_sum));
                    end
                    if (got.best_column !== want.best_column) begin
                        report_mismatch($sformatf("best_column %0d, expected %0d",
                                                  got.best_column, want.best_column));
                    end
                    if (m_tdata[OUT_TDATA_BITS-1:SUM_OUT_BITS+COL_OUT_BITS] !== '0) begin
                        report_mismatch($sformatf("padding bits set, tdata %h", m_tdata));
                    end
                end
            end
            if (recv_gap > 0) begin
                m_tready <= 1'b0;
                recv_gap <= recv_gap - 1;
            end else begin
                m_tready <= 1'b1;
                if ($urandom_range(0, 4) == 0) begin
                    recv_gap <= pick_gap();
                end
            end
        end
    end

    // Wait until every cell is in and every result out, then let the
    // pipeline settle before touching the register.
    task automatic wait_for_drain();
        do begin
            @(posedge aclk);
        end while (pending_cells.size() != 0 || s_tvalid || expected_results.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
    endtask

    task automatic write_grid_size(input logic [SIZE_BITS-1:0] size);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= size;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        grid_size_q = size;
        col_pos = 0;
        row_pos = 0;
        size_writes++;
    endtask

    task automatic queue_cells(input int count, input cell_style_t style);
        for (int i = 0; i < count; i++) begin
            pending_cells.push_back(pick_cell(style));
        end
    endtask

    // Stimulus: directed grids first, then random phases, then an oversized
    // size value and a grid at the reset size.
    initial begin : stimulus
        int                   random_cells;
        int                   n;
        int                   r;
        int                   cells;
        logic [SIZE_BITS-1:0] size;
        cell_style_t          style;

        grid_size_q = SIZE_BITS'(SIZE_RESET);
        col_pos = 0;
        row_pos = 0;
        left_sum = '0;
        best_sum_q = '0;
        best_col_q = 0;
        foreach (path_sums[i]) begin
            path_sums[i] = '0;
        end
        random_cells = 0;

        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // Reset size of four, every cell at the minimum: all bottom sums tie.
        for (int i = 0; i < 16; i++) begin
            pending_cells.push_back(16'h8000);
        end
        wait_for_drain();

        // Single cell grids, then a size of zero acting as one.
        write_grid_size(7'd1);
        pending_cells.push_back(16'h7fff);
        pending_cells.push_back(16'h0000);
        wait_for_drain();
        write_grid_size(7'd0);
        pending_cells.push_back(16'hffff);
        wait_for_drain();

        // Partial grid; the next size write starts over mid-grid.
        write_grid_size(7'd2);
        for (int i = 0; i < 3; i++) begin
            pending_cells.push_back(16'h7fff);
        end
        wait_for_drain();

        // Random phases: mostly small grids, some with a partial tail.
        while (random_cells < RANDOM_CELLS) begin
            r = $urandom_range(0, 99);
            if (r < 70) begin
                size = SIZE_BITS'($urandom_range(2, 6));
            end else if (r < 80) begin
                size = 7'd1;
            end else if (r < 85) begin
                size = 7'd0;
            end else begin
                size = SIZE_BITS'($urandom_range(7, 12));
            end
            r = $urandom_range(0, 99);
            style = (r < 60) ? CELLS_UNIFORM : (r < 85) ? CELLS_TIES : CELLS_EXTREMES;
            no_idling = ($urandom_range(0, 3) == 0);
            n = size_in_use(size);
            cells = n * n * $urandom_range(1, 3);
            if (n > 1 && $urandom_range(0, 3) == 0) begin
                cells += $urandom_range(1, n * n - 1);
            end
            write_grid_size(size);
            queue_cells(cells, style);
            random_cells += cells;
            wait_for_drain();
        end

        // Oversized value acting as the largest size: two full rows and part of a
        // third, then a fresh grid at the reset size.
        no_idling = 1'b0;
        write_grid_size(7'd127);
        queue_cells(2 * GRID_MAX + 5, CELLS_EXTREMES);
        wait_for_drain();
        write_grid_size(7'd4);
        queue_cells(16, CELLS_UNIFORM);
        wait_for_drain();

        if (expected_results.size() != 0) begin
            report_mismatch($sformatf("%0d results never arrived", expected_results.size()));
        end
        $display("Run covered %0d cells over %0d size writes, %0d grid results checked.",
                 cells_accepted, size_writes, results_checked);
        if (error_count == 0) begin
            $display("tb_top: clean");
        end else begin
            $display("tb_top: errors");
        end
        $finish;
    end

    // Watchdog well beyond the slowest legal run.
    initial begin : watchdog
        #(30_000_000);
        $display("tb_top: errors");
        $finish;
    end

endmodule

FILE: files.f
hdl/gmdp_pkg.sv
hdl/gmdp_row_mem.sv
hdl/gmdp_out_fifo.sv
hdl/grid_max_descending_path.sv
dv/tb_top.sv
